// File: rtl/li_chao_min_line_tree_assert.svh
// Assertion macros shared by the checker files of the line tree block.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef LI_CHAO_MIN_LINE_TREE_ASSERT_SVH
`define LI_CHAO_MIN_LINE_TREE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCMT_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line tree assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define LCMT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line tree assertion failed");

`endif

// File: rtl/lcmt_pkg.sv
// Package of the line tree block: field widths, word structs, codes and states.
// Used by the top level and by its checker; depends on nothing.
package lcmt_pkg;

	localparam int X_BITS_DEF = 10;
	localparam int FIELD_X_W  = 10;
	localparam int SLOPE_W    = 32;
	localparam int ICPT_W     = 48;
	localparam int VALUE_W    = 64;
	localparam int CFG_IDX_W  = 1;

	localparam logic signed [VALUE_W-1:0] NO_LINE_VALUE = 64'sd4000000000000000000;

	localparam logic REQ_INSERT = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_LOW  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOMAIN_HIGH = 1'b1;

	typedef struct packed {
		logic                        req_type;
		logic signed [SLOPE_W-1:0]   line_slope;
		logic signed [ICPT_W-1:0]    line_intercept;
		logic        [FIELD_X_W-1:0] query_x;
	} req_word_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] min_value;
		logic                      is_empty;
	} rsp_word_t;

	typedef struct packed {
		logic                      valid;
		logic signed [SLOPE_W-1:0] slope;
		logic signed [ICPT_W-1:0]  intercept;
	} node_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_CHECK,
		ST_MUL_L,
		ST_MUL_M,
		ST_DECIDE,
		ST_RESULT
	} state_t;

endpackage

// File: rtl/lcmt_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module lcmt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/li_chao_min_line_tree.sv
// Top level of the minimum line tree: sequencer, shared multiplier and node store.
// Depends on lcmt_pkg and lcmt_ram.
//
//   port group   direction   handshake          word
//   req_*        in          req_valid/stall    req_word_t (insert or query)
//   rsp_*        out         rsp_valid/stall    rsp_word_t (one per query)
//   cfg_*        in          cfg_we             domain_low, domain_high
//
// A tree level of an insert runs node read, check, two multiplier passes and a decision with
// write back; a query skips the second multiplier pass, and an empty node needs only read and check.
// After reset the node store is swept clear before req_stall drops.
// A finished result waits in the output register while the next word is taken.
module li_chao_min_line_tree #(
	parameter int X_BITS = lcmt_pkg::X_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_stall,
	input  lcmt_pkg::req_word_t            req_word,
	output logic                           rsp_valid,
	input  logic                           rsp_stall,
	output lcmt_pkg::rsp_word_t            rsp_word,
	input  logic                           cfg_we,
	input  logic [lcmt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [lcmt_pkg::FIELD_X_W-1:0] cfg_data
);

	localparam int XW    = X_BITS;
	localparam int IDX_W = X_BITS + 1;
	localparam int DEPTH = 2 << X_BITS;
	localparam int DSW   = lcmt_pkg::SLOPE_W + 1;
	localparam int DIW   = lcmt_pkg::ICPT_W + 1;
	localparam int PW    = DSW + XW + 1;
	localparam int VW    = lcmt_pkg::VALUE_W;
	localparam int NW    = $bits(lcmt_pkg::node_t);

	lcmt_pkg::state_t state_q, state_d;

	logic [IDX_W-1:0] clr_q;
	logic [XW-1:0]    lo_q, hi_q;
	logic [XW-1:0]    l_q, r_q, qx_q;
	logic [IDX_W-1:0] idx_q;
	logic             is_query_q;

	logic signed [lcmt_pkg::SLOPE_W-1:0] m_q, sm_q;
	logic signed [lcmt_pkg::ICPT_W-1:0]  b_q, sb_q;
	logic signed [DSW-1:0]               opa_q;
	logic signed [DIW-1:0]               addend_q;
	logic signed [PW-1:0]                mul_q;
	logic                                left_win_q;
	logic signed [VW-1:0]                best_q;
	logic                                found_q;

	logic                rsp_valid_q;
	lcmt_pkg::rsp_word_t rsp_word_q;

	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [NW-1:0]        ram_wdata;
	lcmt_pkg::node_t      rd_node;
	logic [NW-1:0]        ram_rdata;

	logic [XW-1:0]        mid_w;
	logic [XW-1:0]        xop;
	logic signed [PW-1:0] prod_w;
	logic signed [VW-1:0] sum_w;
	logic                 sum_neg;
	logic                 req_acc;
	logic                 req_x_out;
	logic [XW-1:0]        req_x;
	logic                 slot_free;

	assign rd_node   = lcmt_pkg::node_t'(ram_rdata);
	assign mid_w     = l_q + ((r_q - l_q) >> 1);
	assign prod_w    = opa_q * $signed({1'b0, xop});
	assign sum_w     = VW'(mul_q) + VW'(addend_q);
	assign sum_neg   = sum_w[VW-1];
	assign req_acc   = req_valid && !req_stall;
	assign req_x     = XW'(req_word.query_x);
	assign req_x_out = (hi_q < lo_q) || (req_x < lo_q) || (req_x > hi_q);
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_word  = rsp_word_q;

	lcmt_ram #(
		.WIDTH(NW),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (idx_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			lcmt_pkg::ST_CLEAR: begin
				if (clr_q == '1) begin
					state_d = lcmt_pkg::ST_IDLE;
				end
			end
			lcmt_pkg::ST_IDLE: begin
				if (req_valid) begin
					if (req_word.req_type == lcmt_pkg::REQ_QUERY) begin
						state_d = req_x_out ? lcmt_pkg::ST_RESULT : lcmt_pkg::ST_READ;
					end else begin
						state_d = (hi_q < lo_q) ? lcmt_pkg::ST_IDLE : lcmt_pkg::ST_READ;
					end
				end
			end
			lcmt_pkg::ST_READ: begin
				state_d = lcmt_pkg::ST_CHECK;
			end
			lcmt_pkg::ST_CHECK: begin
				if (rd_node.valid) begin
					state_d = lcmt_pkg::ST_MUL_L;
				end else if (!is_query_q) begin
					state_d = lcmt_pkg::ST_IDLE;
				end else begin
					state_d = (l_q == r_q) ? lcmt_pkg::ST_RESULT : lcmt_pkg::ST_READ;
				end
			end
			lcmt_pkg::ST_MUL_L: begin
				state_d = is_query_q ? lcmt_pkg::ST_DECIDE : lcmt_pkg::ST_MUL_M;
			end
			lcmt_pkg::ST_MUL_M: begin
				state_d = lcmt_pkg::ST_DECIDE;
			end
			lcmt_pkg::ST_DECIDE: begin
				if (l_q != r_q) begin
					state_d = lcmt_pkg::ST_READ;
				end else begin
					state_d = is_query_q ? lcmt_pkg::ST_RESULT : lcmt_pkg::ST_IDLE;
				end
			end
			lcmt_pkg::ST_RESULT: begin
				if (slot_free) begin
					state_d = lcmt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = lcmt_pkg::ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		req_stall = (state_q != lcmt_pkg::ST_IDLE);
		ram_we    = 1'b0;
		ram_waddr = idx_q;
		ram_wdata = {1'b1, m_q, b_q};
		xop       = l_q;
		unique case (state_q)
			lcmt_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
			end
			lcmt_pkg::ST_CHECK: begin
				ram_we = !rd_node.valid && !is_query_q;
			end
			lcmt_pkg::ST_MUL_L: begin
				xop = is_query_q ? qx_q : l_q;
			end
			lcmt_pkg::ST_MUL_M: begin
				xop = mid_w;
			end
			lcmt_pkg::ST_DECIDE: begin
				ram_we = !is_query_q && sum_neg;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lcmt_pkg::ST_CLEAR;
			clr_q       <= '0;
			lo_q        <= '0;
			hi_q        <= XW'(10'd1023);
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == lcmt_pkg::ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					lcmt_pkg::CFG_DOMAIN_LOW:  lo_q <= XW'(cfg_data);
					lcmt_pkg::CFG_DOMAIN_HIGH: hi_q <= XW'(cfg_data);
					default: begin
					end
				endcase
			end
			if (state_q == lcmt_pkg::ST_RESULT && slot_free) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		mul_q <= prod_w;
		unique case (state_q)
			lcmt_pkg::ST_IDLE: begin
				if (req_acc) begin
					is_query_q <= (req_word.req_type == lcmt_pkg::REQ_QUERY);
					m_q        <= req_word.line_slope;
					b_q        <= req_word.line_intercept;
					qx_q       <= req_x;
					l_q        <= lo_q;
					r_q        <= hi_q;
					idx_q      <= IDX_W'(1);
					best_q     <= lcmt_pkg::NO_LINE_VALUE;
					found_q    <= 1'b0;
				end
			end
			lcmt_pkg::ST_CHECK: begin
				sm_q <= rd_node.slope;
				sb_q <= rd_node.intercept;
				if (is_query_q) begin
					opa_q    <= DSW'(rd_node.slope);
					addend_q <= DIW'(rd_node.intercept);
					if (!rd_node.valid && l_q != r_q) begin
						if (qx_q <= mid_w) begin
							idx_q <= {idx_q[IDX_W-2:0], 1'b0};
							r_q   <= mid_w;
						end else begin
							idx_q <= {idx_q[IDX_W-2:0], 1'b1};
							l_q   <= mid_w + 1'b1;
						end
					end
				end else begin
					opa_q    <= DSW'(m_q) - DSW'(rd_node.slope);
					addend_q <= DIW'(b_q) - DIW'(rd_node.intercept);
				end
			end
			lcmt_pkg::ST_MUL_M: begin
				left_win_q <= sum_neg;
			end
			lcmt_pkg::ST_DECIDE: begin
				if (is_query_q) begin
					found_q <= 1'b1;
					if (sum_w < best_q) begin
						best_q <= sum_w;
					end
					if (l_q != r_q) begin
						if (qx_q <= mid_w) begin
							idx_q <= {idx_q[IDX_W-2:0], 1'b0};
							r_q   <= mid_w;
						end else begin
							idx_q <= {idx_q[IDX_W-2:0], 1'b1};
							l_q   <= mid_w + 1'b1;
						end
					end
				end else begin
					if (sum_neg) begin
						m_q <= sm_q;
						b_q <= sb_q;
					end
					if (l_q != r_q) begin
						if (left_win_q != sum_neg) begin
							idx_q <= {idx_q[IDX_W-2:0], 1'b0};
							r_q   <= mid_w;
						end else begin
							idx_q <= {idx_q[IDX_W-2:0], 1'b1};
							l_q   <= mid_w + 1'b1;
						end
					end
				end
			end
			lcmt_pkg::ST_RESULT: begin
				if (slot_free) begin
					rsp_word_q.min_value <= best_q;
					rsp_word_q.is_empty  <= !found_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

// File: rtl/lcmt_checker.sv
// Port-level checker of the minimum line tree, bound to the top level.
// Depends on lcmt_pkg and li_chao_min_line_tree_assert.svh.
`include "li_chao_min_line_tree_assert.svh"

module lcmt_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input lcmt_pkg::req_word_t req_word,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input lcmt_pkg::rsp_word_t rsp_word
);

	logic req_acc;
	logic query_acc;
	logic empty_ok;

	assign req_acc   = req_valid && !req_stall;
	assign query_acc = req_acc && (req_word.req_type == lcmt_pkg::REQ_QUERY);
	assign empty_ok  = (rsp_word.min_value == lcmt_pkg::NO_LINE_VALUE);

	// A stalled result word stays offered and unchanged.
	`LCMT_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_word))

	// A query keeps the block busy for at least the following cycle.
	`LCMT_ASSERT_NEXT(a_query_busy, query_acc, req_stall)

	// No result word can appear in the cycle right after a word is taken.
	`LCMT_ASSERT_NEXT(a_no_instant_rsp, req_acc, !$rose(rsp_valid))

	// An empty answer always carries the no-line value.
	`LCMT_ASSERT_SAME(a_empty_value, rsp_valid && rsp_word.is_empty, empty_ok)

endmodule

bind li_chao_min_line_tree lcmt_checker u_lcmt_checker (.*);

// File: test/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for li_chao_min_line_tree: random and directed inserts and queries
// are checked against a line tree tracked inside the bench. Needs lcmt_pkg and the block.
module tb;

	localparam int NODES   = 2 << lcmt_pkg::X_BITS_DEF;
	localparam int SETTLE  = 100;
	localparam int SLOPE_W = lcmt_pkg::SLOPE_W;
	localparam int ICPT_W  = lcmt_pkg::ICPT_W;
	localparam int X_W     = lcmt_pkg::FIELD_X_W;

	class lower_envelope_board;
		logic signed [SLOPE_W-1:0] kept_slope [NODES];
		logic signed [ICPT_W-1:0]  kept_icpt [NODES];
		bit                        kept_used [NODES];
		longint                    span_lo;
		longint                    span_hi;
		lcmt_pkg::rsp_word_t       pending_answers [$];
		int                        mismatches;

		function new();
			foreach (kept_used[i]) kept_used[i] = 1'b0;
			span_lo = 0;
			span_hi = 1023;
			mismatches = 0;
		endfunction

		function void set_span(longint lo, longint hi);
			span_lo = lo;
			span_hi = hi;
		endfunction

		function int pending();
			return pending_answers.size();
		endfunction

		function longint line_value(longint m, longint b, longint x);
			return m * x + b;
		endfunction

		function void place_line(longint m, longint b);
			int     idx;
			longint l, r, mid, held_m, held_b;
			bit     left_win, mid_win;
			idx = 1;
			l = span_lo;
			r = span_hi;
			if (r < l) return;
			while (idx < NODES) begin
				if (!kept_used[idx]) begin
					kept_slope[idx] = m[SLOPE_W-1:0];
					kept_icpt[idx] = b[ICPT_W-1:0];
					kept_used[idx] = 1'b1;
					return;
				end
				held_m = kept_slope[idx];
				held_b = kept_icpt[idx];
				mid = l + (r - l) / 2;
				left_win = line_value(m, b, l) < line_value(held_m, held_b, l);
				mid_win = line_value(m, b, mid) < line_value(held_m, held_b, mid);
				if (mid_win) begin
					kept_slope[idx] = m[SLOPE_W-1:0];
					kept_icpt[idx] = b[ICPT_W-1:0];
					m = held_m;
					b = held_b;
				end
				if (l == r) return;
				if (left_win != mid_win) begin
					idx = idx * 2;
					r = mid;
				end else begin
					idx = idx * 2 + 1;
					l = mid + 1;
				end
			end
		endfunction

		function lcmt_pkg::rsp_word_t min_at(longint x);
			lcmt_pkg::rsp_word_t ans;
			int                  idx;
			longint              l, r, mid, v, best;
			bit                  found;
			idx = 1;
			l = span_lo;
			r = span_hi;
			best = lcmt_pkg::NO_LINE_VALUE;
			found = 1'b0;
			if (r >= l && x >= l && x <= r) begin
				while (idx < NODES) begin
					if (kept_used[idx]) begin
						v = line_value(kept_slope[idx], kept_icpt[idx], x);
						found = 1'b1;
						if (v < best) best = v;
					end
					if (l == r) break;
					mid = l + (r - l) / 2;
					if (x <= mid) begin
						idx = idx * 2;
						r = mid;
					end else begin
						idx = idx * 2 + 1;
						l = mid + 1;
					end
				end
			end
			ans.min_value = best;
			ans.is_empty = !found;
			return ans;
		endfunction

		function void take_request(lcmt_pkg::req_word_t w);
			if (w.req_type == lcmt_pkg::REQ_INSERT) begin
				place_line($signed(w.line_slope), $signed(w.line_intercept));
			end else begin
				pending_answers.push_back(min_at(w.query_x));
			end
		endfunction

		function void check_answer(lcmt_pkg::rsp_word_t got);
			lcmt_pkg::rsp_word_t want;
			if (pending_answers.size() == 0) begin
				mismatches++;
				$display("%0t: expected no word, actual min_value %0d is_empty %0b", $time,
					$signed(got.min_value), got.is_empty);
				return;
			end
			want = pending_answers.pop_front();
			if (got.min_value !== want.min_value || got.is_empty !== want.is_empty) begin
				mismatches++;
				$display("%0t: expected min_value %0d is_empty %0b, actual %0d %0b", $time,
					$signed(want.min_value), want.is_empty,
					$signed(got.min_value), got.is_empty);
			end
		endfunction
	endclass

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           req_valid = 1'b0;
	logic                           req_stall;
	lcmt_pkg::req_word_t            req_word = '0;
	logic                           rsp_valid;
	logic                           rsp_stall = 1'b0;
	lcmt_pkg::rsp_word_t            rsp_word;
	logic                           cfg_we = 1'b0;
	logic [lcmt_pkg::CFG_IDX_W-1:0] cfg_index = lcmt_pkg::CFG_DOMAIN_LOW;
	logic [X_W-1:0]                 cfg_data = '0;

	lower_envelope_board board = new();
	int                  sent_count = 0;
	int                  rsp_cycles = 0;

	li_chao_min_line_tree uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_word  (req_word),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp_word  (rsp_word),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall) board.check_answer(rsp_word);
		rsp_cycles++;
		rsp_stall <= ((rsp_cycles % 3000) >= 800) && ($urandom_range(0, 99) < 11);
	end

	task automatic send_request(input lcmt_pkg::req_word_t w);
		bit calm;
		calm = (sent_count % 500) >= 350;
		if (!calm && $urandom_range(0, 99) < 11) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		req_valid <= 1'b1;
		req_word <= w;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.take_request(w);
		sent_count++;
	endtask

	task automatic send_line(input longint m, input longint b);
		lcmt_pkg::req_word_t w;
		w.req_type = lcmt_pkg::REQ_INSERT;
		w.line_slope = m[SLOPE_W-1:0];
		w.line_intercept = b[ICPT_W-1:0];
		w.query_x = X_W'($urandom);
		send_request(w);
	endtask

	task automatic send_query(input int x);
		lcmt_pkg::req_word_t w;
		w.req_type = lcmt_pkg::REQ_QUERY;
		w.line_slope = $urandom;
		w.line_intercept = ICPT_W'({$urandom, $urandom});
		w.query_x = X_W'(x);
		send_request(w);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic set_domain(input int lo, input int hi);
		cfg_we <= 1'b1;
		cfg_index <= lcmt_pkg::CFG_DOMAIN_LOW;
		cfg_data <= lo[X_W-1:0];
		@(posedge clk);
		cfg_index <= lcmt_pkg::CFG_DOMAIN_HIGH;
		cfg_data <= hi[X_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_span(lo, hi);
	endtask

	function automatic lcmt_pkg::req_word_t rand_request(input int lo, input int hi);
		lcmt_pkg::req_word_t       w;
		logic signed [SLOPE_W-1:0] s;
		longint                    c;
		case ($urandom_range(0, 9))
			0: s = $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: s = 32'sh7FFF_FFFF;
					1: s = 32'sh8000_0000;
					2: s = 0;
					default: s = -1;
				endcase
			end
			2, 3: s = int'($urandom_range(0, 8)) - 4;
			default: s = int'($urandom_range(0, 4000)) - 2000;
		endcase
		case ($urandom_range(0, 9))
			0: c = {$urandom, $urandom};
			1: c = $urandom_range(0, 1) ? 64'sh7FFF_FFFF_FFFF : -64'sh8000_0000_0000;
			2, 3: c = 100 * (longint'($urandom_range(0, 16)) - 8);
			default: c = longint'($urandom_range(0, 2000000)) - 1000000;
		endcase
		w.req_type = $urandom_range(0, 1) ? lcmt_pkg::REQ_QUERY : lcmt_pkg::REQ_INSERT;
		w.line_slope = s;
		w.line_intercept = c[ICPT_W-1:0];
		if (lo <= hi && $urandom_range(0, 9) < 8)
			w.query_x = X_W'($urandom_range(lo, hi));
		else
			w.query_x = X_W'($urandom);
		return w;
	endfunction

	task automatic run_random(input int lo, input int hi, input int count);
		wait_idle();
		set_domain(lo, hi);
		repeat (count) send_request(rand_request(lo, hi));
	endtask

	initial begin
		int lo;
		int hi;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		set_domain(0, 1023);

		send_query(0);
		send_query(1023);
		send_line(1, 0);
		send_line(1, 0);
		send_line(-1, 1023);
		send_line(64'sh7FFF_FFFF, 64'sh7FFF_FFFF_FFFF);
		send_line(-64'sh8000_0000, -64'sh8000_0000_0000);
		send_line(0, 0);
		send_query(0);
		send_query(1023);
		send_query(511);
		send_query(512);

		wait_idle();
		set_domain(100, 200);
		send_query(50);
		send_query(100);
		send_query(200);
		send_query(201);
		send_line(2, -300);
		send_query(150);

		wait_idle();
		set_domain(300, 299);
		send_line(5, 5);
		send_query(300);

		wait_idle();
		set_domain(1023, 1023);
		send_line(-7, 7);
		send_query(1023);
		send_query(0);

		wait_idle();
		set_domain(0, 0);
		send_line(3, -3);
		send_query(0);

		run_random(0, 1023, 600);
		lo = $urandom_range(0, 511);
		hi = $urandom_range(lo, 1023);
		run_random(lo, hi, 400);
		run_random(0, 0, 80);
		run_random(1023, 1023, 80);
		hi = $urandom_range(0, 1000);
		run_random(hi + $urandom_range(1, 23), hi, 40);
		run_random(0, 1023, 400);
		lo = $urandom_range(0, 1023);
		hi = $urandom_range(lo, 1023);
		run_random(lo, hi, 350);

		wait_idle();
		if (board.mismatches == 0 && board.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end
endmodule
